@@ rtl/frfs_pkg.sv @@
// Shared types and constants of the frame rotate, flip and shift engine.
package frfs_pkg;

  localparam int OP_W      = 4;
  localparam int SIDE_W    = 7;
  localparam int COORD_W   = 6;
  localparam int COLOR_W   = 8;
  localparam int PIX_W     = 3 * COLOR_W;
  localparam int AMT_W     = 16;
  localparam int IN_DATA_W = 56;

  localparam logic [SIDE_W-1:0] SIDE_RESET  = 7'd64;
  localparam logic [PIX_W-1:0]  WHITE_PIXEL = 24'hFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 4'd0,
    OP_READ    = 4'd1,
    OP_UP      = 4'd2,
    OP_DOWN    = 4'd3,
    OP_LEFT    = 4'd4,
    OP_RIGHT   = 4'd5,
    OP_ROT_CW  = 4'd6,
    OP_ROT_CCW = 4'd7,
    OP_FLIP_V  = 4'd8,
    OP_FLIP_H  = 4'd9
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ACCESS = 5'b00010,
    ST_SWEEP  = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    MODE_SHIFT  = 3'd0,
    MODE_ROT1   = 3'd1,
    MODE_ROT2   = 3'd2,
    MODE_ROT3   = 3'd3,
    MODE_FLIP_V = 3'd4,
    MODE_FLIP_H = 3'd5
  } mode_t;

endpackage

@@ rtl/frame_rotate_flip_shift_engine_top.sv @@
// Top level of the frame rotate, flip and shift engine with its double-buffered frame store.
//
// Usage: items arrive on the s_ stream channel, the opcode in s_tuser and the pixel address,
// colour and amount in s_tdata. Every item gives exactly one transfer on the m_ channel;
// m_tuser is set when that transfer carries a pixel that was read, otherwise m_tdata is zero.
// cfg_wen/cfg_wdata set the side of the square frame; write it only while the block is idle.
// Both frame banks live in one memory with one write port and one registered read port.
// A write, read or no-op item goes from the access state to the result state. A move, turn
// or mirror walks the frame one pixel a cycle through the shared source address unit, then
// drains its last write and swaps banks; a turn by a multiple of four skips the walk.
// s_tready is high only in the idle state, so one item is in flight at a time.
// A finished result waits in the output register; if the receiver stalls, the block takes
// the next item, works on it and holds its result back until the register is free.
// Reset (rst, synchronous) selects the first bank, sets the side to 64 and empties the
// output; the frame contents are undefined until written.
module frame_rotate_flip_shift_engine_top #(
  parameter int MAX_SIDE = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [frfs_pkg::SIDE_W-1:0]    cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pixel_row, pixel_column, red_in, green_in, blue_in, amount, zero pad
  input  logic [frfs_pkg::IN_DATA_W-1:0] s_tdata,
  // opcode
  input  logic [frfs_pkg::OP_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // red_out, green_out, blue_out
  output logic [frfs_pkg::PIX_W-1:0]     m_tdata,
  // read_valid
  output logic [0:0]                     m_tuser
);
  import frfs_pkg::*;

  localparam int AW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int BAW  = 2 * AW;
  localparam int SCW  = ((AW > AMT_W) ? AW : AMT_W) + 2;

  // Control state
  state_t                   state, state_next;
  logic                     active_sel;
  logic [SIDE_W-1:0]        frame_side;
  logic                     wr_pend;

  // Item registers
  op_t                      op;
  logic [COORD_W-1:0]       row_q, col_q;
  logic [PIX_W-1:0]         pix_q;
  logic signed [AMT_W-1:0]  amt_q;
  logic                     rd_hit;

  // Sweep registers
  mode_t                    mode;
  logic                     shift_row;
  logic signed [SCW-1:0]    offset;
  logic [AW-1:0]            i_cnt, j_cnt;
  logic [AW-1:0]            wi, wj;
  logic                     wr_white;

  // Memory ports
  logic [PIX_W-1:0]         mem [2**(BAW+1)];
  logic                     mem_we, mem_re;
  logic [BAW:0]             mem_waddr, mem_raddr;
  logic [PIX_W-1:0]         mem_wdata, rdata;

  logic [SW-1:0]            side_eff;
  logic [AW-1:0]            last;
  logic                     in_range;
  logic [BAW-1:0]           pix_addr;
  logic [1:0]               q_cw, q_ccw;
  logic signed [SCW-1:0]    amt_ext;

  logic [AW-1:0]            rev_i, rev_j, mov, src_r, src_c;
  logic signed [SCW-1:0]    sum;
  logic                     shift_ok, src_white, sweep_end;

  // A side of zero acts as one and a side beyond the store acts as the store size.
  always_comb begin
    if (frame_side == '0) begin
      side_eff = SW'(1);
    end else if (32'(frame_side) > MAX_SIDE) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = SW'(frame_side);
    end
  end

  assign last     = AW'(side_eff - SW'(1));
  assign in_range = (32'(row_q) < 32'(side_eff)) && (32'(col_q) < 32'(side_eff));
  assign pix_addr = {AW'(row_q), AW'(col_q)};
  assign q_cw     = amt_q[1:0];
  assign q_ccw    = 2'(~amt_q[1:0] + 2'd1);
  assign amt_ext  = SCW'(amt_q);

  // Shared source address unit: one adder for moves, reversed counters for turns and mirrors.
  assign rev_i    = last - i_cnt;
  assign rev_j    = last - j_cnt;
  assign mov      = shift_row ? i_cnt : j_cnt;
  assign sum      = $signed(SCW'(mov)) + offset;
  assign shift_ok = (sum >= 0) && (sum < $signed(SCW'(side_eff)));
  assign sweep_end = (i_cnt == last) && (j_cnt == last);

  always_comb begin
    src_r     = i_cnt;
    src_c     = j_cnt;
    src_white = 1'b0;
    unique case (mode)
      MODE_SHIFT: begin
        src_r     = shift_row ? AW'(sum) : i_cnt;
        src_c     = shift_row ? j_cnt : AW'(sum);
        src_white = !shift_ok;
      end
      MODE_ROT1: begin
        src_r = rev_j;
        src_c = i_cnt;
      end
      MODE_ROT2: begin
        src_r = rev_i;
        src_c = rev_j;
      end
      MODE_ROT3: begin
        src_r = j_cnt;
        src_c = rev_i;
      end
      MODE_FLIP_V: begin
        src_r = rev_i;
      end
      MODE_FLIP_H: begin
        src_c = rev_j;
      end
      default: begin
        src_white = 1'b1;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {active_sel, pix_addr};
    mem_raddr = {active_sel, pix_addr};
    mem_wdata = pix_q;
    if (state == ST_ACCESS && in_range) begin
      mem_we = (op == OP_WRITE);
      mem_re = (op == OP_READ);
    end
    if (state == ST_SWEEP) begin
      mem_re    = !src_white;
      mem_raddr = {active_sel, src_r, src_c};
    end
    // The second stage of the sweep writes the rebuilt pixel into the idle bank.
    if ((state == ST_SWEEP || state == ST_DRAIN) && wr_pend) begin
      mem_we    = 1'b1;
      mem_waddr = {~active_sel, wi, wj};
      mem_wdata = wr_white ? WHITE_PIXEL : rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        state_next = ST_DONE;
        unique case (op)
          OP_UP, OP_DOWN, OP_LEFT, OP_RIGHT, OP_FLIP_V, OP_FLIP_H: state_next = ST_SWEEP;
          OP_ROT_CW:  if (q_cw != 2'd0) state_next = ST_SWEEP;
          OP_ROT_CCW: if (q_ccw != 2'd0) state_next = ST_SWEEP;
          default: state_next = ST_DONE;
        endcase
      end
      ST_SWEEP: begin
        if (sweep_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active_sel <= 1'b0;
      frame_side <= SIDE_RESET;
      wr_pend    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        frame_side <= cfg_wdata;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      wr_pend <= 1'b0;
      unique case (state)
        ST_SWEEP: begin
          wr_pend <= 1'b1;
        end
        ST_DRAIN: begin
          active_sel <= ~active_sel;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload and sweep registers carry no reset.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          op    <= op_t'(s_tuser);
          row_q <= s_tdata[5:0];
          col_q <= s_tdata[11:6];
          pix_q <= {s_tdata[19:12], s_tdata[27:20], s_tdata[35:28]};
          amt_q <= s_tdata[51:36];
        end
      end
      ST_ACCESS: begin
        rd_hit    <= (op == OP_READ) && in_range;
        i_cnt     <= '0;
        j_cnt     <= '0;
        shift_row <= (op == OP_UP) || (op == OP_DOWN);
        if (op == OP_UP || op == OP_LEFT) begin
          offset <= amt_ext;
        end else begin
          offset <= -amt_ext;
        end
        unique case (op)
          OP_ROT_CW:  mode <= mode_t'({1'b0, q_cw});
          OP_ROT_CCW: mode <= mode_t'({1'b0, q_ccw});
          OP_FLIP_V:  mode <= MODE_FLIP_V;
          OP_FLIP_H:  mode <= MODE_FLIP_H;
          default:    mode <= MODE_SHIFT;
        endcase
      end
      ST_SWEEP: begin
        wi       <= i_cnt;
        wj       <= j_cnt;
        wr_white <= src_white;
        if (j_cnt == last) begin
          j_cnt <= '0;
          i_cnt <= i_cnt + AW'(1);
        end else begin
          j_cnt <= j_cnt + AW'(1);
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tuser <= rd_hit;
          m_tdata <= rd_hit ? {rdata[7:0], rdata[15:8], rdata[23:16]} : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // The frame store is never written while the block waits for an item.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("frame store written while idle");

  // Banks swap only at the end of a rebuild.
  a_swap_after_drain: assert property (@(posedge clk) disable iff (rst)
    (active_sel != $past(active_sel)) |-> $past(state == ST_DRAIN))
    else $error("bank swap outside a rebuild");

  // A new result appears only out of the result state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result without a finished item");

  // A result without read data carries zero colour bytes.
  a_zero_when_no_read: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("colour bytes set on a result without read data");

  // The sweep counters stay inside the frame.
  a_sweep_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (i_cnt <= last) && (j_cnt <= last))
    else $error("sweep counter beyond the frame");

endmodule

@@ bench/tb_frame_rotate_flip_shift_engine_top.sv @@
// Self-checking stream bench for the frame rotate, flip and shift engine.
module tb_frame_rotate_flip_shift_engine_top;
  import frfs_pkg::*;

  localparam int MAX_SIDE    = 64;
  localparam int FRAME_CELLS = MAX_SIDE * MAX_SIDE;
  localparam int PAD_W       = IN_DATA_W - 2 * COORD_W - PIX_W - AMT_W;

  localparam logic [OP_W-1:0]   OP_UNUSED_FIRST = 4'd10;
  localparam int                OP_UNUSED_COUNT = 6;
  localparam logic [SIDE_W-1:0] SIDE_ZERO       = 7'd0;
  localparam logic [SIDE_W-1:0] SIDE_ALL_ONES   = 7'd127;

  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 10;
  localparam int MAX_REPORTS    = 40;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_ITEMS    = 20;

  typedef logic [PIX_W-1:0] rgb_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               hit;
  } pixel_answer_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_wen   = 1'b0;
  logic [SIDE_W-1:0]    cfg_wdata = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  // pixel_row, pixel_column, red_in, green_in, blue_in, amount, zero pad
  logic [IN_DATA_W-1:0] s_tdata   = '0;
  // opcode
  logic [OP_W-1:0]      s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  // red_out, green_out, blue_out
  logic [PIX_W-1:0]     m_tdata;
  // read_valid
  logic [0:0]           m_tuser;

  frame_rotate_flip_shift_engine_top #(
    .MAX_SIDE(MAX_SIDE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Behavioral copy of the two frame banks and the side register.
  rgb_t              frame_bank [2][FRAME_CELLS];
  int                live_bank    = 0;
  logic [SIDE_W-1:0] side_setting = SIDE_RESET;

  pixel_answer_t expected_results [$];

  bit calm            = 1'b0;
  bit rx_hold_pending = 1'b0;

  int items_sent         = 0;
  int reads_sent         = 0;
  int rebuilds_sent      = 0;
  int results_checked    = 0;
  int fail_count         = 0;
  int side_settings_used = 1;

  function automatic int frame_extent();
    int s;
    s = side_setting;
    if (s < 1) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s;
  endfunction

  // Rebuild the live frame into the idle bank, then swap banks.
  function automatic void rebuild_frame(mode_t mode, int dr, int dc);
    int   side;
    int   sr;
    int   sc;
    rgb_t v;
    side = frame_extent();
    for (int i = 0; i < side; i++) begin
      for (int j = 0; j < side; j++) begin
        sr = i;
        sc = j;
        case (mode)
          MODE_ROT1: begin
            sr = side - 1 - j;
            sc = i;
          end
          MODE_ROT2: begin
            sr = side - 1 - i;
            sc = side - 1 - j;
          end
          MODE_ROT3: begin
            sr = j;
            sc = side - 1 - i;
          end
          MODE_FLIP_V: sr = side - 1 - i;
          MODE_FLIP_H: sc = side - 1 - j;
          default: begin
            sr = i - dr;
            sc = j - dc;
          end
        endcase
        if (mode == MODE_SHIFT && (sr < 0 || sr >= side || sc < 0 || sc >= side)) begin
          v = WHITE_PIXEL;
        end else begin
          v = frame_bank[live_bank][sr * MAX_SIDE + sc];
        end
        frame_bank[1 - live_bank][i * MAX_SIDE + j] = v;
      end
    end
    live_bank = 1 - live_bank;
  endfunction

  function automatic pixel_answer_t predict_item(logic [OP_W-1:0] op,
                                                 logic [COORD_W-1:0] row, col,
                                                 rgb_t rgb, logic [AMT_W-1:0] amt_raw);
    pixel_answer_t ans;
    int            side;
    int            amt;
    int            turns;
    int            addr;
    bit            in_frame;
    ans      = '0;
    side     = frame_extent();
    amt      = $signed(amt_raw);
    addr     = int'(row) * MAX_SIDE + int'(col);
    in_frame = int'(row) < side && int'(col) < side;
    case (op)
      OP_WRITE: if (in_frame) frame_bank[live_bank][addr] = rgb;
      OP_READ: begin
        if (in_frame) begin
          ans.red   = frame_bank[live_bank][addr][23:16];
          ans.green = frame_bank[live_bank][addr][15:8];
          ans.blue  = frame_bank[live_bank][addr][7:0];
          ans.hit   = 1'b1;
        end
      end
      OP_UP:    rebuild_frame(MODE_SHIFT, -amt, 0);
      OP_DOWN:  rebuild_frame(MODE_SHIFT, amt, 0);
      OP_LEFT:  rebuild_frame(MODE_SHIFT, 0, -amt);
      OP_RIGHT: rebuild_frame(MODE_SHIFT, 0, amt);
      OP_ROT_CW, OP_ROT_CCW: begin
        // Counterclockwise turns are clockwise turns by the negated amount.
        turns = (op == OP_ROT_CW) ? (amt & 3) : ((-amt) & 3);
        case (turns)
          1: rebuild_frame(MODE_ROT1, 0, 0);
          2: rebuild_frame(MODE_ROT2, 0, 0);
          3: rebuild_frame(MODE_ROT3, 0, 0);
          default: ;
        endcase
      end
      OP_FLIP_V: rebuild_frame(MODE_FLIP_V, 0, 0);
      OP_FLIP_H: rebuild_frame(MODE_FLIP_H, 0, 0);
      default: ;
    endcase
    return ans;
  endfunction

  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic rgb_t random_color();
    if ($urandom_range(0, 7) == 0) return WHITE_PIXEL;
    return PIX_W'($urandom);
  endfunction

  function automatic logic [AMT_W-1:0] shift_amount(int side);
    if ($urandom_range(0, 3) == 0) return AMT_W'($urandom);
    return AMT_W'($urandom_range(0, 2 * side + 2) - (side + 1));
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (fail_count < MAX_REPORTS) begin
      $display("Mismatch on result %0d, %s: got %0h, expected %0h",
               results_checked, field, got, want);
    end
    fail_count++;
  endtask

  // Offer one item and record what it should produce once the transfer happens.
  task automatic send_item(logic [OP_W-1:0] op, logic [COORD_W-1:0] row, col,
                           rgb_t rgb, logic [AMT_W-1:0] amt);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{PAD_W{1'b0}}, amt, rgb[7:0], rgb[15:8], rgb[23:16], col, row};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    expected_results.push_back(predict_item(op, row, col, rgb, amt));
    items_sent++;
    if (op == OP_READ) begin
      reads_sent++;
    end else if (op >= OP_UP && op <= OP_FLIP_H) begin
      rebuilds_sent++;
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write every pixel of the frame so that no later read touches an unwritten cell.
  task automatic fill_frame();
    int side;
    bit was_calm;
    side     = frame_extent();
    was_calm = calm;
    if (side > 16) calm = 1'b1;
    for (int r = 0; r < side; r++) begin
      for (int c = 0; c < side; c++) begin
        send_item(OP_WRITE, COORD_W'(r), COORD_W'(c), random_color(), AMT_W'($urandom));
      end
    end
    calm = was_calm;
  endtask

  task automatic resize_frame(logic [SIDE_W-1:0] setting);
    int old_side;
    wait_idle();
    old_side  = frame_extent();
    cfg_wen   <= 1'b1;
    cfg_wdata <= setting;
    @(posedge clk);
    cfg_wen <= 1'b0;
    side_setting = setting;
    side_settings_used++;
    if (frame_extent() != old_side) fill_frame();
  endtask

  task automatic read_back();
    int side;
    side = frame_extent();
    if (side <= 16) begin
      for (int r = 0; r < side; r++) begin
        for (int c = 0; c < side; c++) begin
          send_item(OP_READ, COORD_W'(r), COORD_W'(c), random_color(), AMT_W'($urandom));
        end
      end
    end else begin
      send_item(OP_READ, '0, '0, random_color(), AMT_W'($urandom));
      send_item(OP_READ, '0, COORD_W'(side - 1), random_color(), AMT_W'($urandom));
      send_item(OP_READ, COORD_W'(side - 1), '0, random_color(), AMT_W'($urandom));
      send_item(OP_READ, COORD_W'(side - 1), COORD_W'(side - 1), random_color(),
                AMT_W'($urandom));
      repeat (40) begin
        send_item(OP_READ, COORD_W'($urandom_range(0, side - 1)),
                  COORD_W'($urandom_range(0, side - 1)), random_color(), AMT_W'($urandom));
      end
    end
  endtask

  task automatic send_random_item();
    int               side;
    int               pick;
    logic [OP_W-1:0]  op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [AMT_W-1:0] amt;
    side = frame_extent();
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      op = OP_WRITE;
    end else if (pick < 55) begin
      op = OP_READ;
    end else if (pick < 95) begin
      op = OP_UP + $urandom_range(0, 7);
    end else begin
      op = OP_UNUSED_FIRST + $urandom_range(0, OP_UNUSED_COUNT - 1);
    end
    if ($urandom_range(0, 4) != 0) begin
      row = COORD_W'($urandom_range(0, side - 1));
      col = COORD_W'($urandom_range(0, side - 1));
    end else begin
      row = COORD_W'($urandom);
      col = COORD_W'($urandom);
    end
    if (op >= OP_UP && op <= OP_RIGHT) begin
      amt = shift_amount(side);
    end else begin
      amt = AMT_W'($urandom);
    end
    send_item(op, row, col, random_color(), amt);
  endtask

  task automatic test_full_frame_access();
    fill_frame();
    send_item(OP_READ, '0, '0, random_color(), '0);
    send_item(OP_READ, '0, '1, random_color(), '1);
    send_item(OP_READ, '1, '0, random_color(), '0);
    send_item(OP_READ, '1, '1, random_color(), '1);
    send_item(OP_WRITE, '1, '1, WHITE_PIXEL, '1);
    send_item(OP_WRITE, '0, '0, '0, '0);
    send_item(OP_READ, '1, '1, '0, '0);
    send_item(OP_READ, '0, '0, '1, '1);
  endtask

  task automatic test_full_frame_transforms();
    send_item(OP_ROT_CW, '0, '0, random_color(), AMT_W'(1));
    send_item(OP_LEFT, '0, '0, random_color(), AMT_W'(-3));
    send_item(OP_FLIP_V, '0, '0, random_color(), AMT_W'($urandom));
    read_back();
  endtask

  // Settings of zero and above the maximum must clamp to the nearest legal side.
  task automatic test_side_clamp();
    resize_frame(SIDE_ALL_ONES);
    send_item(OP_WRITE, '1, '1, random_color(), '0);
    send_item(OP_READ, '1, '1, random_color(), '0);
    send_item(OP_FLIP_H, '0, '0, random_color(), '0);
    send_item(OP_READ, '1, '0, random_color(), '0);
    resize_frame(SIDE_ZERO);
    send_item(OP_WRITE, '0, COORD_W'(1), random_color(), '0);
    send_item(OP_READ, '0, COORD_W'(1), random_color(), '0);
    send_item(OP_DOWN, '0, '0, random_color(), '0);
    send_item(OP_ROT_CW, '0, '0, random_color(), AMT_W'(1));
    send_item(OP_READ, '0, '0, random_color(), '0);
  endtask

  task automatic test_out_of_frame_access();
    resize_frame(SIDE_W'(4));
    send_item(OP_WRITE, COORD_W'(4), '0, random_color(), '0);
    send_item(OP_WRITE, '0, '1, random_color(), '0);
    send_item(OP_READ, '1, '1, random_color(), '0);
    send_item(OP_READ, '0, COORD_W'(4), random_color(), '0);
    send_item(OP_READ, COORD_W'(3), COORD_W'(3), random_color(), '0);
  endtask

  task automatic test_shift_limits();
    send_item(OP_DOWN, '0, '0, random_color(), '0);
    send_item(OP_RIGHT, '0, '0, random_color(), AMT_W'(1));
    send_item(OP_UP, '0, '0, random_color(), AMT_W'(-2));
    read_back();
    // A distance equal to the side leaves an all-white frame.
    send_item(OP_LEFT, '0, '0, random_color(), AMT_W'(4));
    read_back();
    fill_frame();
    send_item(OP_RIGHT, '0, '0, random_color(), AMT_W'(32767));
    send_item(OP_DOWN, '0, '0, random_color(), AMT_W'(-32768));
    read_back();
  endtask

  task automatic test_turns_and_mirrors();
    resize_frame(SIDE_W'(5));
    // Net turns of zero must not swap banks; the clockwise turn by -1 is a turn by three.
    send_item(OP_ROT_CW, '0, '0, random_color(), '0);
    send_item(OP_ROT_CCW, '0, '0, random_color(), AMT_W'(4));
    send_item(OP_ROT_CW, '0, '0, random_color(), AMT_W'(-1));
    read_back();
    send_item(OP_ROT_CCW, '0, '0, random_color(), AMT_W'(1));
    send_item(OP_ROT_CW, '0, '0, random_color(), AMT_W'(2));
    send_item(OP_ROT_CCW, '0, '0, random_color(), AMT_W'(-32767));
    read_back();
    send_item(OP_FLIP_V, '0, '0, random_color(), '0);
    send_item(OP_FLIP_H, '0, '0, random_color(), '0);
    read_back();
  endtask

  task automatic test_unused_opcodes();
    send_item(OP_UNUSED_FIRST, '0, '0, random_color(), AMT_W'($urandom));
    send_item(OP_UNUSED_FIRST + OP_UNUSED_COUNT - 1, '1, '1, random_color(), '1);
    send_item(OP_READ, '0, '0, random_color(), '0);
  endtask

  // Hold the result side off long enough that the block fills up and stalls its input.
  task automatic test_output_backpressure();
    resize_frame(SIDE_W'(3));
    calm            = 1'b1;
    rx_hold_pending = 1'b1;
    repeat (8) send_random_item();
    calm = 1'b0;
    read_back();
  endtask

  task automatic test_random_traffic();
    logic [SIDE_W-1:0] setting;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      setting = ($urandom_range(0, 9) == 0) ? SIDE_ZERO : SIDE_W'($urandom_range(1, 9));
      resize_frame(setting);
      calm = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) send_random_item();
      read_back();
      calm = 1'b0;
    end
  endtask

  initial begin : result_sink
    int stall;
    @(posedge clk);
    forever begin
      if (rx_hold_pending) begin
        rx_hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if (calm || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = idle_length();
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_checker
    pixel_answer_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("transfer with nothing expected", m_tdata, '0);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[7:0] !== want.red) report_mismatch("red_out", m_tdata[7:0], want.red);
        if (m_tdata[15:8] !== want.green) begin
          report_mismatch("green_out", m_tdata[15:8], want.green);
        end
        if (m_tdata[23:16] !== want.blue) begin
          report_mismatch("blue_out", m_tdata[23:16], want.blue);
        end
        if (m_tuser[0] !== want.hit) report_mismatch("read_valid", m_tuser[0], want.hit);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_full_frame_access();
    test_full_frame_transforms();
    test_side_clamp();
    test_out_of_frame_access();
    test_shift_limits();
    test_turns_and_mirrors();
    test_unused_opcodes();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();
    $display("Covered %0d items: %0d pixel reads and %0d rebuild requests over %0d side settings,",
             items_sent, reads_sent, rebuilds_sent, side_settings_used);
    $display("with random stalls on both sides and one long output hold; %0d results checked.",
             results_checked);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Timed out with %0d results still outstanding.", expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
rtl/frfs_pkg.sv
rtl/frame_rotate_flip_shift_engine_top.sv
bench/tb_frame_rotate_flip_shift_engine_top.sv
